FILE: design/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg - shared types and constants of the bit-flag run-length expander
// Holds the decode phase type, the input kind codes, the decoder state and
// result structures, and the short-code length table.
// ----------------------------------------------------------------------------
package brle_pkg;

  // Input kind codes, also used for the "wanted next" field.
  localparam logic [1:0] KIND_CTRL  = 2'd0;
  localparam logic [1:0] KIND_LEN   = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  // Register indexes of the configuration port.
  localparam logic REG_LAYOUT = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  localparam logic [4:0] FLAGS_PER_WORD  = 5'd16;
  localparam logic [4:0] RUN_BIAS        = 5'd4;
  localparam logic [8:0] EXT_BIAS        = 9'd20;
  localparam logic [1:0] LAST_CODE_BIT   = 2'd2;
  localparam logic [8:0] MAX_RUN_COUNT   = 9'd275;
  // A control word can resolve at most three code bits plus one flag bit.
  localparam int         MAX_SETTLE_BITS = 4;

  typedef enum logic [2:0] {
    PH_FLAG   = 3'd0,
    PH_LIT    = 3'd1,
    PH_RUNVAL = 3'd2,
    PH_CODE   = 3'd3,
    PH_DESC   = 3'd4,
    PH_EXT    = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  typedef struct packed {
    logic        swapped;
    logic [15:0] output_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] flag_word;
    logic [4:0]  flags_left;
    logic [4:0]  pending_run;
    logic [7:0]  held_value;
    phase_t      phase;
    logic [1:0]  bits_taken;
    logic [4:0]  descriptor_low;
    logic [15:0] bytes_written;
  } dec_state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] run_value;
    logic [8:0] run_count;
    logic [1:0] want;
    logic       finished;
  } res_t;

  // Input kind that a phase is waiting for.
  function automatic logic [1:0] want_of(input phase_t phase);
    logic [1:0] k;
    case (phase)
      PH_LIT, PH_RUNVAL: k = KIND_VALUE;
      PH_DESC, PH_EXT:   k = KIND_LEN;
      default:           k = KIND_CTRL;
    endcase
    return k;
  endfunction

  // Run length of a code ended by a 0 bit after pos leading 1 bits.
  // A result of zero means the length comes from a descriptor.
  function automatic logic [2:0] code_length(input logic swapped, input logic [1:0] pos);
    logic [2:0] len;
    case (pos)
      2'd0:    len = swapped ? 3'd0 : 3'd2;
      2'd1:    len = swapped ? 3'd2 : 3'd3;
      default: len = swapped ? 3'd3 : 3'd4;
    endcase
    return len;
  endfunction

endpackage

FILE: design/bitflag_run_length_expander_unit.sv
// ----------------------------------------------------------------------------
// bitflag_run_length_expander_unit - run-expansion stage of a decompressor
// A request accepted into the input register is decoded and its result is
// written to the result register; a stall on the result channel holds it.
// Throughput: one request per cycle while the result channel is not stalled,
// limited by the single decode pass between the input and result registers.
// Reset (synchronous, rst_n low): decoder state, registers and both valid
// flags are cleared; the block waits for a flag bit with no flags loaded.
// ----------------------------------------------------------------------------
module bitflag_run_length_expander_unit import brle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_data,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_emit,
  output logic [7:0]  out_run_value,
  output logic [8:0]  out_run_count,
  output logic [1:0]  out_want,
  output logic        out_finished,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The design is a two-register pipeline. The input register holds one
  // request; the decode step combines it with the architectural state and
  // writes both the new state and the result in the same cycle. Because the
  // state only moves when a request is decoded, each request sees exactly the
  // state left by the one before it, and requests can follow back to back.

  cfg_t        cfg;
  dec_state_t  st_r;
  dec_state_t  st_nxt;
  res_t        res;
  res_t        out_res_r;
  logic        out_vld_r;
  logic        in_vld_r;
  logic [1:0]  in_kind_r;
  logic [15:0] in_data_r;
  logic        advance;

  brle_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  brle_decode u_decode (
    .in_kind_i (in_kind_r),
    .in_data_i (in_data_r),
    .st_i      (st_r),
    .cfg_i     (cfg),
    .st_nxt_o  (st_nxt),
    .res_o     (res)
  );

  // A held request is decoded whenever the result register is empty or its
  // current result is being taken in the same cycle.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  // The input register refills in the cycle it drains; a waiting result that is
  // not taken holds the request and stops the next one from being taken.
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  // Request payload carries no reset; it is qualified by in_vld_r.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_kind_r <= in_kind;
      in_data_r <= in_data;
    end
  end

  // Architectural decoder state, updated once per decoded request. The
  // all-zero state is the flag-bit phase with no flags loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_emit      = out_res_r.emit;
  assign out_run_value = out_res_r.run_value;
  assign out_run_count = out_res_r.run_count;
  assign out_want      = out_res_r.want;
  assign out_finished  = out_res_r.finished;

  // Once decoding has ended, no later request may produce a run or ask for
  // anything but a control word.
  a_finished_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_emit && out_want == KIND_CTRL)
    else $error("finished result carries a run or a request for input");

  // Every run written has a legal length.
  a_run_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_emit |-> out_run_count != 9'd0 && out_run_count <= MAX_RUN_COUNT)
    else $error("run count out of range");

  // The end of decoding is final.
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_DONE |=> st_r.phase == PH_DONE)
    else $error("decoder left the finished phase");

  // The output byte count never goes backwards.
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> st_r.bytes_written >= $past(st_r.bytes_written))
    else $error("output byte count decreased");

  // State only changes when a request is decoded.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r))
    else $error("decoder state changed without a decoded request");

endmodule

FILE: design/brle_cfg_regs.sv
// ----------------------------------------------------------------------------
// brle_cfg_regs - configuration registers of the run-length expander
// APB-style slave holding the token layout select and the output limit.
// ----------------------------------------------------------------------------
module brle_cfg_regs import brle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[2])
        REG_LAYOUT: cfg_nxt.swapped      = pwdata[0];
        REG_LIMIT:  cfg_nxt.output_limit = pwdata[15:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register 0 (the low address bits are ignored) reads the layout bit.
  always_comb begin
    case (paddr[2])
      REG_LAYOUT: prdata = {31'd0, cfg_r.swapped};
      REG_LIMIT:  prdata = {16'd0, cfg_r.output_limit};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_r;

endmodule

FILE: design/brle_decode.sv
// ----------------------------------------------------------------------------
// brle_decode - single-request decode step of the run-length expander
// Takes the registered request and the current decoder state and works out
// the next state and the result in one combinational pass.
// ----------------------------------------------------------------------------
module brle_decode import brle_pkg::*; (
  input  logic [1:0]  in_kind_i,
  input  logic [15:0] in_data_i,
  input  dec_state_t  st_i,
  input  cfg_t        cfg_i,
  output dec_state_t  st_nxt_o,
  output res_t        res_o
);

  dec_state_t  s;
  logic        run_go;
  logic [7:0]  run_val;
  logic [8:0]  run_cnt;
  logic        code_bit;
  logic [2:0]  code_len;
  logic [7:0]  byte_v;
  logic [16:0] sum_v;

  always_comb begin
    s        = st_i;
    run_go   = 1'b0;
    run_val  = '0;
    run_cnt  = '0;
    code_bit = 1'b0;
    code_len = '0;
    sum_v    = '0;
    byte_v   = in_data_i[7:0];

    if (s.phase != PH_DONE && in_kind_i == want_of(s.phase)) begin
      case (s.phase)
        PH_LIT: begin
          run_go  = 1'b1;
          run_val = byte_v;
          run_cnt = 9'd1;
          s.phase = PH_FLAG;
        end
        PH_RUNVAL: begin
          s.held_value = byte_v;
          s.bits_taken = '0;
          s.phase      = PH_CODE;
        end
        PH_DESC: begin
          if (byte_v[7:4] != 4'd0) begin
            s.pending_run = {1'b0, byte_v[3:0]} + RUN_BIAS;
            run_go        = 1'b1;
            run_val       = s.held_value;
            run_cnt       = {5'd0, byte_v[7:4]} + {4'd0, RUN_BIAS};
            s.phase       = PH_FLAG;
          end else begin
            s.descriptor_low = {1'b0, byte_v[3:0]} + RUN_BIAS;
            s.phase          = PH_EXT;
          end
        end
        PH_EXT: begin
          run_go           = 1'b1;
          run_val          = s.held_value;
          run_cnt          = {1'b0, byte_v} + EXT_BIAS;
          s.pending_run    = s.descriptor_low;
          s.descriptor_low = '0;
          s.phase          = PH_FLAG;
        end
        default: begin
          s.flag_word  = in_data_i;
          s.flags_left = FLAGS_PER_WORD;
        end
      endcase

      // Consume flag and code bits until an input is needed again.
      for (int i = 0; i < MAX_SETTLE_BITS; i++) begin
        if ((s.phase == PH_FLAG || s.phase == PH_CODE) && s.flags_left != '0) begin
          code_bit     = s.flag_word[15];
          s.flag_word  = {s.flag_word[14:0], 1'b0};
          s.flags_left = s.flags_left - 5'd1;
          if (s.phase == PH_FLAG) begin
            s.phase = code_bit ? PH_RUNVAL : PH_LIT;
          end else if (code_bit && s.bits_taken < LAST_CODE_BIT) begin
            s.bits_taken = s.bits_taken + 2'd1;
          end else if (code_bit && s.bytes_written >= cfg_i.output_limit) begin
            s.phase      = PH_DONE;
            s.bits_taken = '0;
          end else begin
            if (code_bit) begin
              code_len = cfg_i.swapped ? 3'd4 : 3'd0;
            end else begin
              code_len = code_length(cfg_i.swapped, s.bits_taken);
            end
            s.bits_taken = '0;
            if (code_len != 3'd0) begin
              run_go  = 1'b1;
              run_val = s.held_value;
              run_cnt = {6'd0, code_len};
              s.phase = PH_FLAG;
            end else if (s.pending_run > RUN_BIAS) begin
              run_go        = 1'b1;
              run_val       = s.held_value;
              run_cnt       = {4'd0, s.pending_run};
              s.pending_run = '0;
              s.phase       = PH_FLAG;
            end else if (s.pending_run == RUN_BIAS) begin
              s.pending_run    = '0;
              s.descriptor_low = '0;
              s.phase          = PH_EXT;
            end else begin
              s.phase = PH_DESC;
            end
          end
        end
      end
    end

    // At most one run per request, so a single saturating add suffices.
    if (run_go) begin
      sum_v           = {1'b0, s.bytes_written} + {8'd0, run_cnt};
      s.bytes_written = sum_v[16] ? 16'hFFFF : sum_v[15:0];
    end
  end

  assign st_nxt_o           = s;
  assign res_o.emit         = run_go;
  assign res_o.run_value    = run_val;
  assign res_o.run_count    = run_cnt;
  assign res_o.want         = (s.phase == PH_DONE) ? KIND_CTRL : want_of(s.phase);
  assign res_o.finished     = (s.phase == PH_DONE);

endmodule

FILE: tb/bitflag_run_length_expander_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitflag_run_length_expander_unit_test - regression of the run expander
// Drives control words, length bytes and staged value bytes into the block,
// keeps its own model of the flag and code decoding, and checks every result
// against it. Directed code patterns come first, then random streams under
// varying back-pressure, a long-run pass that saturates the output count, and
// a final pass that ends decoding on an escape at the output limit.
// ----------------------------------------------------------------------------
module bitflag_run_length_expander_unit_test;
  import brle_pkg::*;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] ADDR_LAYOUT = {REG_LAYOUT, 2'b00};
  localparam logic [2:0] ADDR_LIMIT  = {REG_LIMIT, 2'b00};
  // The one kind code that no decode phase ever asks for.
  localparam logic [1:0] KIND_BAD    = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = KIND_CTRL;
  logic [15:0] in_data = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_emit;
  logic [7:0]  out_run_value;
  logic [8:0]  out_run_count;
  logic [1:0]  out_want;
  logic        out_finished;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Percentage of cycles in which the sender holds back or the receiver stalls.
  int src_idle_pct = 31;
  int sink_idle_pct = 45;
  int fail_count = 0;

  // Results still owed by the block, oldest first.
  res_t results_due[$];

  // Our own copy of the decoder: configuration first, then the run state.
  logic        layout_swapped = 1'b0;
  logic [15:0] limit_count = 16'd0;
  logic [15:0] flag_bits = 16'd0;
  logic [4:0]  flags_remaining = 5'd0;
  logic [4:0]  pending_len = 5'd0;
  logic [7:0]  held_byte = 8'd0;
  phase_t      dec_phase = PH_FLAG;
  logic [1:0]  code_ones = 2'd0;
  logic [4:0]  desc_low = 5'd0;
  logic [15:0] written_count = 16'd0;
  logic        decode_ended = 1'b0;
  res_t        step_out;

  bitflag_run_length_expander_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_emit     (out_emit),
    .out_run_value(out_run_value),
    .out_run_count(out_run_count),
    .out_want     (out_want),
    .out_finished (out_finished),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // The receiver decides at each falling edge whether it will take a result.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  // The stream the decoder is waiting on in its present phase.
  function automatic logic [1:0] kind_wanted();
    logic [1:0] k;
    k = KIND_CTRL;
    if (dec_phase == PH_LIT || dec_phase == PH_RUNVAL)
      k = KIND_VALUE;
    else if (dec_phase == PH_DESC || dec_phase == PH_EXT)
      k = KIND_LEN;
    return k;
  endfunction

  // Length coded by a 0 bit that follows the given number of 1 bits. In the
  // plain layout the lengths start at two; in the swapped layout the shortest
  // code means that the length comes from elsewhere.
  function automatic int short_code_len(input logic [1:0] ones);
    int len;
    if (layout_swapped)
      len = (ones == 2'd0) ? 0 : int'(ones) + 1;
    else
      len = int'(ones) + 2;
    return len;
  endfunction

  // Record a run in the result and advance the output count, which sticks
  // at its top value rather than wrapping.
  task automatic add_run(input logic [7:0] value, input int count);
    int total;
    total = int'(written_count) + count;
    step_out.emit = 1'b1;
    step_out.run_value = value;
    step_out.run_count = count[8:0];
    written_count = (total > 65535) ? 16'hFFFF : total[15:0];
  endtask

  // A zero length: use the length left over from the last descriptor if it
  // is a real one, go straight to an extended byte if it is the bare bias,
  // otherwise ask for a fresh descriptor.
  task automatic take_stored_length();
    if (pending_len > RUN_BIAS) begin
      add_run(held_byte, int'(pending_len));
      pending_len = 5'd0;
      dec_phase = PH_FLAG;
    end else if (pending_len == RUN_BIAS) begin
      pending_len = 5'd0;
      desc_low = 5'd0;
      dec_phase = PH_EXT;
    end else begin
      dec_phase = PH_DESC;
    end
  endtask

  task automatic close_code(input int len);
    code_ones = 2'd0;
    if (len != 0) begin
      add_run(held_byte, len);
      dec_phase = PH_FLAG;
    end else begin
      take_stored_length();
    end
  endtask

  // Consume loaded flag bits until the decoder needs a byte or runs dry.
  task automatic walk_flags();
    logic top;
    while (!decode_ended && (dec_phase == PH_FLAG || dec_phase == PH_CODE)
           && flags_remaining != 5'd0) begin
      top = flag_bits[15];
      flag_bits = flag_bits << 1;
      flags_remaining = flags_remaining - 5'd1;
      if (dec_phase == PH_FLAG) begin
        dec_phase = top ? PH_RUNVAL : PH_LIT;
      end else if (!top) begin
        close_code(short_code_len(code_ones));
      end else if (code_ones < LAST_CODE_BIT) begin
        code_ones = code_ones + 2'd1;
      end else if (written_count >= limit_count) begin
        // Escape with the output count at its limit: decoding is over.
        decode_ended = 1'b1;
        dec_phase = PH_DONE;
        code_ones = 2'd0;
      end else begin
        // Escape below the limit: a run of four when swapped, else a zero
        // length.
        close_code(layout_swapped ? 4 : 0);
      end
    end
  endtask

  // Work out the result of one accepted request and queue it.
  task automatic predict_result(input logic [1:0] kind, input logic [15:0] data);
    logic [7:0] lo_byte;
    lo_byte = data[7:0];
    step_out = '0;
    if (!decode_ended && kind == kind_wanted()) begin
      case (dec_phase)
        PH_LIT: begin
          add_run(lo_byte, 1);
          dec_phase = PH_FLAG;
        end
        PH_RUNVAL: begin
          held_byte = lo_byte;
          code_ones = 2'd0;
          dec_phase = PH_CODE;
        end
        PH_DESC: begin
          if (lo_byte[7:4] != 4'd0) begin
            pending_len = {1'b0, lo_byte[3:0]} + RUN_BIAS;
            add_run(held_byte, int'(lo_byte[7:4]) + int'(RUN_BIAS));
            dec_phase = PH_FLAG;
          end else begin
            desc_low = {1'b0, lo_byte[3:0]} + RUN_BIAS;
            dec_phase = PH_EXT;
          end
        end
        PH_EXT: begin
          add_run(held_byte, int'(lo_byte) + int'(EXT_BIAS));
          pending_len = desc_low;
          desc_low = 5'd0;
          dec_phase = PH_FLAG;
        end
        default: begin
          flag_bits = data;
          flags_remaining = FLAGS_PER_WORD;
        end
      endcase
      walk_flags();
    end
    step_out.want = decode_ended ? KIND_CTRL : kind_wanted();
    step_out.finished = decode_ended;
    results_due.push_back(step_out);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [8:0] expv,
                                 input logic [8:0] actv);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
    fail_count++;
  endtask

  // Every result taken off the channel is compared with the oldest one owed.
  always @(posedge clk) begin : result_check
    res_t due;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got emit %0d value %0d count %0d",
                 $time, out_emit, out_run_value, out_run_count);
        fail_count++;
      end else begin
        due = results_due.pop_front();
        if (out_emit !== due.emit)
          report_mismatch("emit", 9'(due.emit), 9'(out_emit));
        if (out_run_value !== due.run_value)
          report_mismatch("run_value", 9'(due.run_value), 9'(out_run_value));
        if (out_run_count !== due.run_count)
          report_mismatch("run_count", due.run_count, out_run_count);
        if (out_want !== due.want)
          report_mismatch("want", 9'(due.want), 9'(out_want));
        if (out_finished !== due.finished)
          report_mismatch("finished", 9'(due.finished), 9'(out_finished));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one request, holding it steady until the block accepts it. Valid is
  // only ever set once per falling edge, so back-to-back requests keep it high.
  task automatic send_request(input logic [1:0] kind, input logic [15:0] data);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_data  <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_result(kind, data);
  endtask

  // Pick the next request from what the decoder is waiting for. long_pct
  // steers length bytes towards extended runs; noise_pct sends a kind the
  // decoder does not want; hint_pct replaces random control words by a fixed
  // pattern. counted tells whether the request does any work.
  task automatic send_next(input int long_pct, input int noise_pct,
                           input logic [15:0] hint, input int hint_pct,
                           output bit counted);
    logic [1:0]  wanted;
    logic [1:0]  kind;
    logic [15:0] data;
    wanted = kind_wanted();
    kind = wanted;
    data = 16'($urandom);
    if ($urandom_range(99) < noise_pct) begin
      kind = wanted + 2'($urandom_range(1, 3));
    end else if (wanted == KIND_CTRL) begin
      if ($urandom_range(99) < hint_pct)
        data = hint;
    end else if (wanted == KIND_LEN && $urandom_range(99) < long_pct) begin
      // A bare-bias descriptor, which asks for an extended byte and leaves a
      // length that sends the next zero length to one as well, or a long
      // extended byte.
      if (dec_phase == PH_DESC)
        data[7:0] = 8'h00;
      else
        data[7:0] = 8'($urandom_range(8'hE0, 8'hFF));
    end
    counted = !decode_ended && kind == wanted;
    send_request(kind, data);
  endtask

  // Write a register over the configuration port, then read it back.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] stored;
    stored = (addr == ADDR_LAYOUT) ? {31'd0, value[0]} : {16'd0, value[15:0]};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_LAYOUT)
      layout_swapped = value[0];
    else
      limit_count = value[15:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== stored) begin
      $display("%0t: register %0d read back, expected %0h, got %0h",
               $time, addr, stored, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop offering requests, let every owed result come out, and let the pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Plain layout. The first word walks a literal, runs of two, three and four,
  // an escape that falls back to a descriptor, and two trailing literals. The
  // second word is all escapes: the bare bias left by a descriptor sends the
  // next one straight to an extended byte, a descriptor with a zero high
  // nibble asks for an extended byte, and a left-over length is used at once.
  task automatic test_directed_codes();
    write_register(ADDR_LAYOUT, 32'd0);
    write_register(ADDR_LIMIT, 32'h0000_FFFF);
    send_request(KIND_BAD, 16'hFFFF);     // never wanted, ignored
    send_request(KIND_CTRL, 16'h5BBC);
    send_request(KIND_LEN, 16'h00AA);     // a value is due, ignored
    send_request(KIND_VALUE, 16'hFF00);   // literal of zero
    send_request(KIND_VALUE, 16'h00FF);   // run of two
    send_request(KIND_VALUE, 16'h1234);   // run of three
    send_request(KIND_VALUE, 16'h8001);   // run of four
    send_request(KIND_VALUE, 16'hABCD);   // escape below the limit
    send_request(KIND_LEN, 16'h55F0);     // largest high nibble
    send_request(KIND_VALUE, 16'h7E81);
    send_request(KIND_VALUE, 16'hC3C3);
    send_request(KIND_CTRL, 16'hFFFF);
    send_request(KIND_VALUE, 16'h0F66);
    send_request(KIND_LEN, 16'hAAFF);     // longest run
    send_request(KIND_VALUE, 16'h3399);
    send_request(KIND_LEN, 16'h800F);     // zero high nibble, largest low one
    send_request(KIND_LEN, 16'h0100);     // shortest extended run
    send_request(KIND_VALUE, 16'h5A5A);   // left-over length used directly
    send_request(KIND_VALUE, 16'hA5A5);
    send_request(KIND_LEN, 16'hFE11);
  endtask

  // Swapped layout: the shortest code picks up the length left over above,
  // then runs of two and three, an escape worth four, and literals.
  task automatic test_swapped_codes();
    wait_drained();
    write_register(ADDR_LAYOUT, 32'd1);
    send_request(KIND_CTRL, 16'hB778);
    send_request(KIND_VALUE, 16'h6611);
    send_request(KIND_VALUE, 16'h99EE);
    send_request(KIND_VALUE, 16'h0080);
    send_request(KIND_VALUE, 16'hFF7F);
    send_request(KIND_VALUE, 16'h4000);
    send_request(KIND_VALUE, 16'h0002);
    send_request(KIND_VALUE, 16'h2001);
  endtask

  // Mostly well-formed random streams with a little noise. The limit stays
  // well above the output count so that decoding carries on.
  task automatic test_random_mix(input int n, input int src_pct, input int sink_pct,
                                 input logic swapped, input logic [15:0] limit);
    int  sent;
    bit  counted;
    wait_drained();
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    write_register(ADDR_LAYOUT, {31'd0, swapped});
    write_register(ADDR_LIMIT, {16'd0, limit});
    sent = 0;
    while (sent < n) begin
      send_next(10, 8, 16'hFFFF, 5, counted);
      if (counted) sent++;
    end
  endtask

  // Long extended runs in the swapped layout, where the shortest code means a
  // zero length, until the output count sticks at its top.
  task automatic test_count_saturation();
    int guard;
    bit counted;
    wait_drained();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_register(ADDR_LAYOUT, 32'd1);
    write_register(ADDR_LIMIT, 32'h0000_FFFF);
    guard = 0;
    while (written_count != 16'hFFFF && !decode_ended && guard < 2000) begin
      send_next(100, 0, 16'hAAAA, 80, counted);
      guard++;
    end
  endtask

  // A zero limit: the first escape ends decoding, after which every request
  // of any kind is ignored and the finished flag stays up.
  task automatic test_output_limit();
    int guard;
    bit counted;
    wait_drained();
    src_idle_pct = 20;
    sink_idle_pct = 20;
    write_register(ADDR_LAYOUT, 32'd0);
    write_register(ADDR_LIMIT, 32'd0);
    guard = 0;
    while (!decode_ended && guard < 500) begin
      send_next(20, 5, 16'hFFFF, 30, counted);
      guard++;
    end
    repeat (12) send_next(0, 50, 16'h0000, 0, counted);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_codes();
    test_swapped_codes();
    test_random_mix(160, 31, 45, 1'b0, 16'hFFFF);
    test_random_mix(160, 45, 31, 1'b1, 16'($urandom_range(16'h9000, 16'hFFFE)));
    test_random_mix(160, 0, 0, 1'b0, 16'($urandom_range(16'hC000, 16'hFFFE)));
    test_count_saturation();
    test_output_limit();
    wait_drained();

    if (fail_count == 0)
      $display("bitflag_run_length_expander_unit regression: pass");
    else
      $display("bitflag_run_length_expander_unit regression: fail");
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #5_000_000;
    $display("bitflag_run_length_expander_unit regression: fail");
    $finish;
  end

endmodule
